// File: rtl/abkf_pkg.sv
// Package for the angle and gyro bias Kalman filter.
// Holds the payload structs, widths and configuration indexes; no dependencies.
`timescale 1ns / 1ps
package abkf_pkg;
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_COV = 24;
	localparam int REG_WIDTH = 31;
	localparam int CFG_IDX_WIDTH = 2;

	localparam logic [CFG_IDX_WIDTH-1:0] CFG_PN_ANGLE = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_PN_BIAS = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_MEAS_NOISE = 2'd2;

	localparam logic [REG_WIDTH-1:0] PN_ANGLE_RST = 31'd16777;
	localparam logic [REG_WIDTH-1:0] PN_BIAS_RST = 31'd50332;
	localparam logic [REG_WIDTH-1:0] MEAS_NOISE_RST = 31'd503316;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] new_angle;
		logic signed [31:0] new_rate;
		logic [24:0]        dt;
	} abkf_in_t;

	typedef struct packed {
		logic signed [31:0] angle_out;
		logic signed [31:0] bias_out;
	} abkf_out_t;

	typedef logic signed [DATA_WIDTH-1:0] dword_t;

	function automatic dword_t sat_add(input dword_t a, input dword_t b, input logic sub);
		logic signed [DATA_WIDTH:0] s;
		dword_t r;
		if (sub) begin
			s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
		end else begin
			s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
		end
		if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
			r = s[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end else begin
			r = s[DATA_WIDTH-1:0];
		end
		return r;
	endfunction
endpackage

// File: rtl/angle_bias_kalman_filter_top.sv
// Two-state angle and gyro bias Kalman filter with one shared multiplier and a serial divider.
// Depends on abkf_pkg.
// Sequence: a load item goes straight to the output state; an update item runs ten
// multiplies on the shared 32x32 multiplier, each followed by its accumulate, and two restoring
// divisions with a 56-bit quotient each, then reaches the output state that raises out_valid.
// One item at a time: the next is taken only once the result transfer is done.
// Reset clears angle, bias, rate and covariance to zero and loads the noise defaults.
`timescale 1ns / 1ps
module angle_bias_kalman_filter_top import abkf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  abkf_in_t                 in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output abkf_out_t                out_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [31:0]              cfg_data
);
	localparam int DW = DATA_WIDTH;
	localparam int DIV_STEPS = DW + FRAC_COV;
	localparam int DCW = $clog2(DIV_STEPS + 1);
	localparam int NIW = $clog2(DW);

	typedef enum logic [4:0] {
		ST_IDLE, ST_M_ANG, ST_A_ANG, ST_M_DP11, ST_A_DP11, ST_M_P00, ST_A_P00,
		ST_M_P11, ST_A_P11, ST_S, ST_DIV0, ST_DIV1, ST_M_K0Y, ST_A_K0Y, ST_M_K1Y,
		ST_A_K1Y, ST_M_C0, ST_A_C0, ST_M_C1, ST_A_C1, ST_M_C2, ST_A_C2, ST_M_C3,
		ST_A_C3, ST_OUT
	} state_t;

	state_t state_q;
	logic [REG_WIDTH-1:0] pn_angle_q, pn_bias_q, meas_noise_q;
	dword_t angle_q, bias_q, rate_q, p00_q, p01_q, p10_q, p11_q;
	dword_t dp11_q, s_q, k0_q, k1_q, y_q, p00o_q, p01o_q, prod_q, meas_q;
	logic [24:0] dt_q;
	logic out_valid_q;
	abkf_out_t out_q;
	logic mul_phase_q;

	// Shared multiplier operands; a product is formed, rounded and saturated.
	dword_t mul_a, mul_b;
	logic signed [2*DW-1:0] full_prod;
	logic [2*DW-1:0] mag_prod, rnd_prod;
	dword_t mul_res;
	logic mul_neg;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_M_ANG:  begin mul_a = DW'(dt_q); mul_b = rate_q; end
			ST_M_DP11: begin mul_a = DW'(dt_q); mul_b = p11_q; end
			ST_M_P00:  begin mul_a = DW'(dt_q); mul_b = dp11_q; end
			ST_M_P11:  begin mul_a = DW'(dt_q); mul_b = DW'(pn_bias_q); end
			ST_M_K0Y:  begin mul_a = k0_q; mul_b = y_q; end
			ST_M_K1Y:  begin mul_a = k1_q; mul_b = y_q; end
			ST_M_C0:   begin mul_a = k0_q; mul_b = p00o_q; end
			ST_M_C1:   begin mul_a = k0_q; mul_b = p01o_q; end
			ST_M_C2:   begin mul_a = k1_q; mul_b = p00o_q; end
			ST_M_C3:   begin mul_a = k1_q; mul_b = p01o_q; end
			default:   begin mul_a = '0; mul_b = '0; end
		endcase
	end

	logic signed [2*DW-1:0] prod_s1;
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_comb begin
		full_prod = prod_s1;
		mul_neg = full_prod[2*DW-1];
		mag_prod = mul_neg ? (2*DW)'(-full_prod) : full_prod;
		rnd_prod = mag_prod + ((2*DW)'(1) << (FRAC_COV - 1));
		if ((rnd_prod >> FRAC_COV) > (2*DW)'({1'b0, {(DW-1){1'b1}}}) + (2*DW)'(mul_neg)) begin
			mul_res = mul_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			mul_res = mul_neg ? -DW'(rnd_prod >> FRAC_COV) : DW'(rnd_prod >> FRAC_COV);
		end
	end

	// Serial restoring divider: (num << 24) / den, truncated, saturated.
	logic [DW-1:0] dv_num_q, dv_den_q;
	logic [DW:0] dv_rem_q;
	logic [DIV_STEPS-1:0] dv_quo_q;
	logic [DCW-1:0] dv_cnt_q;
	logic dv_neg_q, dv_busy_q;
	logic [DW+1:0] dv_shift;
	logic [NIW-1:0] dv_idx;
	logic dv_bit;
	dword_t dv_res;

	always_comb begin
		dv_idx = NIW'(dv_cnt_q - DCW'(FRAC_COV + 1));
		dv_bit = (dv_cnt_q > DCW'(FRAC_COV)) ? dv_num_q[dv_idx] : 1'b0;
		dv_shift = {dv_rem_q, dv_bit};
		if (dv_quo_q[DIV_STEPS-1:DW-1] != '0) begin
			dv_res = dv_neg_q ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			dv_res = dv_neg_q ? -dword_t'(dv_quo_q[DW-1:0]) : dword_t'(dv_quo_q[DW-1:0]);
		end
	end

	logic dv_start;
	dword_t dv_n, dv_d;
	always_comb begin
		dv_start = 1'b0;
		dv_n = p00_q;
		dv_d = s_q;
		if (state_q == ST_S) begin
			dv_start = 1'b1;
		end else if (state_q == ST_DIV1 && !dv_busy_q) begin
			dv_start = 1'b1;
			dv_n = p10_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_cnt_q <= '0;
		end else if (dv_start) begin
			dv_busy_q <= 1'b1;
			dv_cnt_q <= DCW'(DIV_STEPS);
			dv_num_q <= dv_n[DW-1] ? DW'(-dv_n) : DW'(dv_n);
			dv_den_q <= dv_d[DW-1] ? DW'(-dv_d) : DW'(dv_d);
			dv_neg_q <= dv_n[DW-1] ^ dv_d[DW-1];
			dv_rem_q <= '0;
			dv_quo_q <= '0;
		end else if (dv_busy_q) begin
			if (dv_cnt_q == '0) begin
				dv_busy_q <= 1'b0;
			end else begin
				dv_cnt_q <= dv_cnt_q - DCW'(1);
				if (dv_shift >= {2'b0, dv_den_q}) begin
					dv_rem_q <= (DW+1)'(dv_shift - {2'b0, dv_den_q});
					dv_quo_q <= {dv_quo_q[DIV_STEPS-2:0], 1'b1};
				end else begin
					dv_rem_q <= dv_shift[DW:0];
					dv_quo_q <= {dv_quo_q[DIV_STEPS-2:0], 1'b0};
				end
			end
		end
	end

	logic dv_done;
	assign dv_done = dv_busy_q && dv_cnt_q == '0;
	logic s_zero;
	assign s_zero = (s_q == '0);

	// The predicted angle covariance term is summed wide and saturated once.
	logic signed [DW+2:0] inner_wide;
	dword_t inner_sat;
	always_comb begin
		inner_wide = (DW+3)'(prod_q) - (DW+3)'(p01_q) - (DW+3)'(p10_q)
			+ (DW+3)'({1'b0, pn_angle_q});
		if (inner_wide[DW+2:DW-1] == '0 || inner_wide[DW+2:DW-1] == '1) begin
			inner_sat = inner_wide[DW-1:0];
		end else begin
			inner_sat = inner_wide[DW+2] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end
	end

	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_angle_q <= PN_ANGLE_RST;
			pn_bias_q <= PN_BIAS_RST;
			meas_noise_q <= MEAS_NOISE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PN_ANGLE:   pn_angle_q <= cfg_data[REG_WIDTH-1:0];
				CFG_PN_BIAS:    pn_bias_q <= cfg_data[REG_WIDTH-1:0];
				CFG_MEAS_NOISE: meas_noise_q <= cfg_data[REG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			mul_phase_q <= 1'b0;
			angle_q <= '0;
			bias_q <= '0;
			rate_q <= '0;
			p00_q <= '0;
			p01_q <= '0;
			p10_q <= '0;
			p11_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						meas_q <= in_data.new_angle;
						dt_q <= in_data.dt;
						if (in_data.opcode == OP_LOAD) begin
							angle_q <= in_data.new_angle;
							state_q <= ST_OUT;
						end else begin
							rate_q <= sat_add(in_data.new_rate, bias_q, 1'b1);
							state_q <= ST_M_ANG;
						end
					end
				end
				ST_OUT: begin
					out_q.angle_out <= angle_q;
					out_q.bias_out <= bias_q;
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_S: begin
					s_q <= s_q;
					state_q <= ST_DIV0;
				end
				ST_DIV0: begin
					if (dv_done) begin
						k0_q <= s_zero ? '0 : dv_res;
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (dv_done) begin
						k1_q <= s_zero ? '0 : dv_res;
						y_q <= sat_add(meas_q, angle_q, 1'b1);
						p00o_q <= p00_q;
						p01o_q <= p01_q;
						state_q <= ST_M_K0Y;
					end
				end
				ST_M_ANG, ST_M_DP11, ST_M_P00, ST_M_P11, ST_M_K0Y, ST_M_K1Y, ST_M_C0,
				ST_M_C1, ST_M_C2, ST_M_C3: begin
					if (!mul_phase_q) begin
						mul_phase_q <= 1'b1;
					end else begin
						mul_phase_q <= 1'b0;
						prod_q <= mul_res;
						state_q <= state_t'(state_q + 5'd1);
					end
				end
				ST_A_ANG: begin
					angle_q <= sat_add(angle_q, prod_q, 1'b0);
					state_q <= ST_M_DP11;
				end
				ST_A_DP11: begin
					dp11_q <= inner_sat;
					p01_q <= sat_add(p01_q, prod_q, 1'b1);
					p10_q <= sat_add(p10_q, prod_q, 1'b1);
					state_q <= ST_M_P00;
				end
				ST_A_P00: begin
					p00_q <= sat_add(p00_q, prod_q, 1'b0);
					state_q <= ST_M_P11;
				end
				ST_A_P11: begin
					p11_q <= sat_add(p11_q, prod_q, 1'b0);
					s_q <= sat_add(p00_q, DW'(meas_noise_q), 1'b0);
					state_q <= ST_S;
				end
				ST_A_K0Y: begin
					angle_q <= sat_add(angle_q, prod_q, 1'b0);
					state_q <= ST_M_K1Y;
				end
				ST_A_K1Y: begin
					bias_q <= sat_add(bias_q, prod_q, 1'b0);
					state_q <= ST_M_C0;
				end
				ST_A_C0: begin
					p00_q <= sat_add(p00_q, prod_q, 1'b1);
					state_q <= ST_M_C1;
				end
				ST_A_C1: begin
					p01_q <= sat_add(p01_q, prod_q, 1'b1);
					state_q <= ST_M_C2;
				end
				ST_A_C2: begin
					p10_q <= sat_add(p10_q, prod_q, 1'b1);
					state_q <= ST_M_C3;
				end
				ST_A_C3: begin
					p11_q <= sat_add(p11_q, prod_q, 1'b1);
					state_q <= ST_OUT;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q != ST_IDLE)
		else $error("accepted item did not start work");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(out_q))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !in_ready)
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV1 && dv_done) |=> state_q == ST_M_K0Y)
		else $error("second gain division did not finish into update");
endmodule

// File: dv/abkf_checker.sv
// Checker for the angle and gyro bias Kalman filter: watches all three channels,
// predicts each result in fixed point and compares it with the block's output.
// Depends on abkf_pkg.
`timescale 1ns / 1ps
module abkf_checker import abkf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  abkf_in_t                 in_data,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  abkf_out_t                out_data,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [31:0]              cfg_data,
	output int                       errors,
	output int                       pending
);
	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;

	longint angle_est, bias_est, rate_est;
	longint cov[4];
	longint noise_angle, noise_bias, noise_meas;
	abkf_out_t expected_q[$];

	function automatic longint clamp(input longint x);
		if (x > SMAX) return SMAX;
		if (x < SMIN) return SMIN;
		return x;
	endfunction

	function automatic longint magnitude(input longint x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic longint signed_mag(input logic [63:0] m, input bit neg);
		logic [63:0] lim;
		lim = neg ? 64'd2147483648 : 64'd2147483647;
		if (m > lim) m = lim;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint mul_round(input longint a, input longint b);
		logic [63:0] p;
		bit neg;
		neg = (a < 0) != (b < 0);
		p = magnitude(a) * magnitude(b) + 64'h800000;
		return signed_mag(p >> FRAC_COV, neg);
	endfunction

	function automatic longint div_gain(input longint n, input longint d);
		logic [63:0] q;
		bit neg;
		if (d == 0) return 0;
		neg = (n < 0) != (d < 0);
		q = (magnitude(n) << FRAC_COV) / magnitude(d);
		if (q >= 64'd2147483648) return neg ? SMIN : SMAX;
		return signed_mag(q, neg);
	endfunction

	function automatic abkf_out_t filter_step(input abkf_in_t x);
		longint meas, gyro, dt, dp11, inner, s, k0, k1, y, p00, p01;
		abkf_out_t r;
		meas = longint'($signed(x.new_angle));
		if (x.opcode == OP_LOAD) begin
			angle_est = clamp(meas);
		end else begin
			gyro = longint'($signed(x.new_rate));
			dt = longint'({39'd0, x.dt});
			rate_est = clamp(gyro - bias_est);
			angle_est = clamp(angle_est + mul_round(dt, rate_est));
			dp11 = mul_round(dt, cov[3]);
			inner = clamp(dp11 - cov[1] - cov[2] + noise_angle);
			cov[0] = clamp(cov[0] + mul_round(dt, inner));
			cov[1] = clamp(cov[1] - dp11);
			cov[2] = clamp(cov[2] - dp11);
			cov[3] = clamp(cov[3] + mul_round(dt, noise_bias));
			s = clamp(cov[0] + noise_meas);
			k0 = div_gain(cov[0], s);
			k1 = div_gain(cov[2], s);
			y = clamp(meas - angle_est);
			angle_est = clamp(angle_est + mul_round(k0, y));
			bias_est = clamp(bias_est + mul_round(k1, y));
			p00 = cov[0];
			p01 = cov[1];
			cov[0] = clamp(cov[0] - mul_round(k0, p00));
			cov[1] = clamp(cov[1] - mul_round(k0, p01));
			cov[2] = clamp(cov[2] - mul_round(k1, p00));
			cov[3] = clamp(cov[3] - mul_round(k1, p01));
		end
		r.angle_out = angle_est[31:0];
		r.bias_out = bias_est[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		abkf_out_t exp_item;
		if (!arst_n) begin
			angle_est = 0;
			bias_est = 0;
			rate_est = 0;
			for (int i = 0; i < 4; i++) cov[i] = 0;
			noise_angle = longint'({33'd0, PN_ANGLE_RST});
			noise_bias = longint'({33'd0, PN_BIAS_RST});
			noise_meas = longint'({33'd0, MEAS_NOISE_RST});
			errors <= 0;
			pending <= 0;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PN_ANGLE: begin
						noise_angle = longint'({33'd0, cfg_data[30:0]});
					end
					CFG_PN_BIAS: begin
						noise_bias = longint'({33'd0, cfg_data[30:0]});
					end
					CFG_MEAS_NOISE: begin
						noise_meas = longint'({33'd0, cfg_data[30:0]});
					end
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready) expected_q.push_back(filter_step(in_data));
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					if (errors < 10) $display("unexpected result transfer: %h", out_data);
					errors <= errors + 1;
				end else begin
					exp_item = expected_q.pop_front();
					if (exp_item != out_data) begin
						if (errors < 10) begin
							$display("mismatch: angle exp %h got %h, bias exp %h got %h",
								exp_item.angle_out, out_data.angle_out,
								exp_item.bias_out, out_data.bias_out);
						end
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end
endmodule

// File: dv/testbench.sv
// Top of the Kalman filter testbench: clock, reset, stimulus and verdict.
// Depends on abkf_pkg, angle_bias_kalman_filter_top and abkf_checker.
`timescale 1ns / 1ps
module testbench;
	import abkf_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 160;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	abkf_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	abkf_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int errors;
	int pending;
	bit steady = 1'b0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	angle_bias_kalman_filter_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	abkf_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 35);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input abkf_in_t item);
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (!steady && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [31:0] value);
		in_valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_noise(input logic [31:0] pa, input logic [31:0] pb, input logic [31:0] mn);
		drain();
		write_reg(CFG_PN_ANGLE, pa);
		write_reg(CFG_PN_BIAS, pb);
		write_reg(CFG_MEAS_NOISE, mn);
	endtask

	function automatic abkf_in_t make_item(input logic op, input logic [31:0] ang,
		input logic [31:0] rate, input logic [24:0] dt);
		abkf_in_t x;
		x.opcode = op;
		x.new_angle = ang;
		x.new_rate = rate;
		x.dt = dt;
		return x;
	endfunction

	function automatic abkf_in_t random_item();
		abkf_in_t x;
		x.opcode = ($urandom_range(99) < 10) ? OP_LOAD : OP_UPDATE;
		x.new_angle = ($urandom_range(99) < 25) ? $urandom : $signed($urandom_range(0, 8388607)) - 4194304;
		x.new_rate = ($urandom_range(99) < 25) ? $urandom : $signed($urandom_range(0, 4194303)) - 2097152;
		x.dt = ($urandom_range(99) < 20) ? 25'($urandom_range(0, 33554431))
			: 25'($urandom_range(1, 40000));
		return x;
	endfunction

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) begin
			steady = (i >= count / 3) && (i < count / 3 + 60);
			send_item(random_item());
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(make_item(OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 25'd0));
		send_item(make_item(OP_UPDATE, 32'h0001_0000, 32'h0000_8000, 25'd16777));
		send_item(make_item(OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 25'd16777216));
		send_item(make_item(OP_UPDATE, 32'h8000_0000, 32'h8000_0000, 25'h1FF_FFFF));
		send_item(make_item(OP_LOAD, 32'h7FFF_FFFF, 32'h1234_5678, 25'h1AB_CDEF));
		send_item(make_item(OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 25'h1FF_FFFF));
		send_item(make_item(OP_LOAD, 32'h8000_0000, 32'hFFFF_FFFF, 25'd0));
		send_item(make_item(OP_UPDATE, 32'h8000_0000, 32'h8000_0000, 25'd16777216));
		send_item(make_item(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_0001, 25'd1));
		send_item(make_item(OP_LOAD, 32'h0000_0000, 32'h0000_0000, 25'd0));
		for (int i = 0; i < 8; i++) begin
			send_item(make_item(OP_UPDATE, 32'h0002_0000, 32'h0000_4000, 25'd10000));
		end

		set_noise(32'd0, 32'd0, 32'd1);
		random_phase(250);
		set_noise(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		random_phase(250);
		set_noise(32'd0, 32'd0, 32'd0);
		write_reg(CFG_IDX_SPARE, $urandom);
		send_item(make_item(OP_UPDATE, 32'h0001_0000, 32'h0000_1000, 25'd16777));
		random_phase(200);
		set_noise($urandom, $urandom, $urandom | 32'd1);
		random_phase(300);
		set_noise({1'b1, PN_ANGLE_RST}, {1'b1, PN_BIAS_RST}, {1'b1, MEAS_NOISE_RST});
		random_phase(580);

		drain();
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

// File: angle_bias_kalman_filter_top.f
rtl/abkf_pkg.sv
rtl/angle_bias_kalman_filter_top.sv
dv/abkf_checker.sv
dv/testbench.sv
